FILE: hdl/stl_pkg.sv
// Shared types, constants and helpers for the timing line parser.
// No dependencies; imported by every module of the block.

package stl_pkg;

  // line buffer geometry
  localparam int unsigned LINE_MAX_BYTES = 1024;
  localparam int unsigned POS_W          = $clog2(LINE_MAX_BYTES);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_MAX_BYTES - 1);

  // timestamp field geometry
  localparam int unsigned FIELD_LEN_SHORT = 11;
  localparam int unsigned FIELD_LEN_LONG  = 12;
  localparam int unsigned SEP_LEN         = 5;
  localparam int unsigned SEP_LOOKBACK    = 4;
  localparam logic [6:0]  MAX_MIN_SEC     = 7'd59;

  // millisecond totals
  localparam int unsigned TOTAL_W    = 29;
  localparam int unsigned MIN_PROD_W = 23;
  localparam int unsigned SEC_PROD_W = 17;
  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

  // characters
  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_NL    = 8'h0A;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_COMMA = 8'h2C;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [31:0] SEP_WORD = 32'h202D2D3E;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SEP      = 3'd1,
    ST_START_LEN   = 3'd2,
    ST_END_LEN     = 3'd3,
    ST_BAD_CHAR    = 3'd4,
    ST_MINUTES     = 3'd5,
    ST_SECONDS     = 3'd6,
    ST_NOT_CHRONO  = 3'd7
  } status_e;

  // one parsed timestamp
  typedef struct packed {
    logic [6:0] hh;
    logic [6:0] mm;
    logic [6:0] ss;
    logic [9:0] ms;
  } stamp_t;

  typedef struct packed {
    logic start_bad;
    logic start_d11;
    logic end_bad;
    logic end_d11;
  } err_flags_t;

  // everything the scanner knows at the end of a line
  typedef struct packed {
    logic             sep_seen;
    logic [POS_W-1:0] sep_pos;
    logic [POS_W-1:0] byte_pos;
    stamp_t           start_f;
    stamp_t           end_f;
    err_flags_t       flags;
    logic [7:0]       end_len_byte;
  } snap_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

FILE: hdl/stl_byte_scan.sv
// Byte scanner: separator search, field digit accumulation and char checks.
// Depends on stl_pkg; hands a line snapshot to stl_time_calc.

module stl_byte_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    line_byte_i,
  input  logic          line_last_i,
  output logic          snap_valid_o,
  input  logic          snap_stall_i,
  output stl_pkg::snap_t snap_o
);
  import stl_pkg::*;

  localparam logic [3:0] IDX_COLON_HM = 4'd2;
  localparam logic [3:0] IDX_COLON_MS = 4'd5;
  localparam logic [3:0] IDX_COMMA    = 4'd8;
  localparam logic [3:0] IDX_MS_EXTRA = 4'd11;

  typedef struct packed {
    stamp_t f;
    logic   bad;
    logic   d11;
  } take_t;

  function automatic logic [6:0] put7(input logic [6:0] v, input logic [3:0] d);
    logic [10:0] t;
    t = {4'b0, v} * 11'd10 + {7'b0, d};
    return t[6:0];
  endfunction

  function automatic logic [9:0] put10(input logic [9:0] v, input logic [3:0] d);
    logic [13:0] t;
    t = {4'b0, v} * 14'd10 + {10'b0, d};
    return t[9:0];
  endfunction

  // check one byte of a timestamp field and fold its digit in
  function automatic take_t take_byte(input stamp_t f, input logic [3:0] idx,
                                      input logic [7:0] b);
    take_t      t;
    logic       dig;
    logic [3:0] d;
    t.f   = f;
    t.bad = 1'b0;
    t.d11 = 1'b0;
    dig   = is_digit(b);
    d     = dig ? b[3:0] : 4'd0;
    unique case (idx)
      IDX_COLON_HM, IDX_COLON_MS: t.bad = (b != CH_COLON);
      IDX_COMMA:                  t.bad = (b != CH_COMMA);
      IDX_MS_EXTRA: begin
        if (dig) begin
          t.d11  = 1'b1;
          t.f.ms = put10(f.ms, d);
        end
      end
      4'd0, 4'd1: begin
        if (!dig) t.bad = 1'b1;
        else t.f.hh = put7(f.hh, d);
      end
      4'd3, 4'd4: begin
        if (!dig) t.bad = 1'b1;
        else t.f.mm = put7(f.mm, d);
      end
      4'd6, 4'd7: begin
        if (!dig) t.bad = 1'b1;
        else t.f.ss = put7(f.ss, d);
      end
      4'd9, 4'd10: begin
        if (!dig) t.bad = 1'b1;
        else t.f.ms = put10(f.ms, d);
      end
      default: ;
    endcase
    return t;
  endfunction

  logic             pos_lt_limit;
  logic             accept;
  logic [POS_W-1:0] pos_q, pos_d, upd_pos;
  logic [31:0]      recent_q, recent_d, upd_recent;
  logic [POS_W-1:0] sep_pos_q, sep_pos_d, upd_sep_pos;
  logic             sep_seen_q, sep_seen_d, upd_sep_seen;
  stamp_t           start_q, start_d, upd_start;
  stamp_t           end_q, end_d, upd_end;
  err_flags_t       flags_q, flags_d, upd_flags;
  logic [7:0]       end_len_q, end_len_d, upd_end_len;
  logic             ended_q, ended_d, upd_ended;
  logic [POS_W-1:0] rel;
  take_t            ts, te;
  logic             snap_valid_q, snap_valid_d;
  snap_t            snap_q;

  assign accept       = in_valid_i & ~in_stall_o;
  assign in_stall_o   = snap_valid_q & snap_stall_i;
  assign pos_lt_limit = pos_q < POS_LIMIT;
  assign rel          = pos_q - sep_pos_q - POS_W'(SEP_LEN);
  assign ts           = take_byte(start_q, pos_q[3:0], line_byte_i);
  assign te           = take_byte(end_q, rel[3:0], line_byte_i);

  // state after taking the current byte
  always_comb begin
    upd_pos      = pos_q;
    upd_recent   = recent_q;
    upd_sep_pos  = sep_pos_q;
    upd_sep_seen = sep_seen_q;
    upd_start    = start_q;
    upd_end      = end_q;
    upd_flags    = flags_q;
    upd_end_len  = end_len_q;
    upd_ended    = ended_q;
    if (!ended_q) begin
      if (line_byte_i == CH_NUL) begin
        upd_ended = 1'b1;
      end else if (pos_lt_limit) begin
        if (pos_q < POS_W'(FIELD_LEN_LONG)) begin
          upd_start           = ts.f;
          upd_flags.start_bad = flags_q.start_bad | ts.bad;
          upd_flags.start_d11 = flags_q.start_d11 | ts.d11;
        end
        if (sep_seen_q) begin
          if (rel < POS_W'(FIELD_LEN_LONG)) begin
            upd_end           = te.f;
            upd_flags.end_bad = flags_q.end_bad | te.bad;
            upd_flags.end_d11 = flags_q.end_d11 | te.d11;
          end
          if (rel == POS_W'(FIELD_LEN_SHORT)) upd_end_len = line_byte_i;
        end else if ((pos_q >= POS_W'(SEP_LOOKBACK)) && (recent_q == SEP_WORD) &&
                     (line_byte_i == CH_SPACE)) begin
          upd_sep_seen = 1'b1;
          upd_sep_pos  = pos_q - POS_W'(SEP_LOOKBACK);
        end
        upd_recent = {recent_q[23:0], line_byte_i};
        upd_pos    = pos_q + POS_W'(1);
      end
    end
  end

  // next state: hold, take the beat, or clear after the last beat
  always_comb begin
    pos_d      = pos_q;
    recent_d   = recent_q;
    sep_pos_d  = sep_pos_q;
    sep_seen_d = sep_seen_q;
    start_d    = start_q;
    end_d      = end_q;
    flags_d    = flags_q;
    end_len_d  = end_len_q;
    ended_d    = ended_q;
    if (accept) begin
      if (line_last_i) begin
        pos_d      = '0;
        recent_d   = '0;
        sep_pos_d  = '0;
        sep_seen_d = 1'b0;
        start_d    = '0;
        end_d      = '0;
        flags_d    = '0;
        end_len_d  = '0;
        ended_d    = 1'b0;
      end else begin
        pos_d      = upd_pos;
        recent_d   = upd_recent;
        sep_pos_d  = upd_sep_pos;
        sep_seen_d = upd_sep_seen;
        start_d    = upd_start;
        end_d      = upd_end;
        flags_d    = upd_flags;
        end_len_d  = upd_end_len;
        ended_d    = upd_ended;
      end
    end
  end

  // snapshot handshake
  always_comb begin
    if (accept && line_last_i) snap_valid_d = 1'b1;
    else if (!snap_stall_i) snap_valid_d = 1'b0;
    else snap_valid_d = snap_valid_q;
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      recent_q     <= '0;
      sep_pos_q    <= '0;
      sep_seen_q   <= 1'b0;
      start_q      <= '0;
      end_q        <= '0;
      flags_q      <= '0;
      end_len_q    <= '0;
      ended_q      <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      recent_q     <= recent_d;
      sep_pos_q    <= sep_pos_d;
      sep_seen_q   <= sep_seen_d;
      start_q      <= start_d;
      end_q        <= end_d;
      flags_q      <= flags_d;
      end_len_q    <= end_len_d;
      ended_q      <= ended_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  // snapshot payload
  always_ff @(posedge clk_i) begin
    if (accept && line_last_i) begin
      snap_q.sep_seen     <= upd_sep_seen;
      snap_q.sep_pos      <= upd_sep_pos;
      snap_q.byte_pos     <= upd_pos;
      snap_q.start_f      <= upd_start;
      snap_q.end_f        <= upd_end;
      snap_q.flags        <= upd_flags;
      snap_q.end_len_byte <= upd_end_len;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

FILE: hdl/stl_time_calc.sv
// Result pipeline: length and range checks, millisecond products, totals,
// chronology check and output register. Depends on stl_pkg.

module stl_time_calc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         snap_valid_i,
  output logic                         snap_stall_o,
  input  stl_pkg::snap_t               snap_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [stl_pkg::TOTAL_W-1:0]  start_ms_o,
  output logic [stl_pkg::TOTAL_W-1:0]  end_ms_o,
  output logic [2:0]                   status_o,
  output logic                         start_short_ms_o,
  output logic                         end_short_ms_o
);
  import stl_pkg::*;

  typedef struct packed {
    status_e               status;
    logic                  start_ok;
    logic                  end_ok;
    logic                  s_short;
    logic                  e_short;
    logic [TOTAL_W-1:0]    st_h;
    logic [MIN_PROD_W-1:0] st_m;
    logic [SEC_PROD_W-1:0] st_s;
    logic [9:0]            st_ms;
    logic [TOTAL_W-1:0]    et_h;
    logic [MIN_PROD_W-1:0] et_m;
    logic [SEC_PROD_W-1:0] et_s;
    logic [9:0]            et_ms;
  } prod_t;

  typedef struct packed {
    status_e            status;
    logic               start_ok;
    logic               end_ok;
    logic               s_short;
    logic               e_short;
    logic [TOTAL_W-1:0] st;
    logic [TOTAL_W-1:0] et;
  } sum_t;

  typedef struct packed {
    status_e            status;
    logic               s_short;
    logic               e_short;
    logic [TOTAL_W-1:0] start_ms;
    logic [TOTAL_W-1:0] end_ms;
  } res_t;

  logic             v2_q, v3_q, v4_q;
  logic             take2, take3, take4;
  prod_t            prod_d, prod_q;
  sum_t             sum_d, sum_q;
  res_t             res_d, res_q;
  logic [POS_W-1:0] rem;
  logic             len_ok;

  // pipeline flow control
  assign take4        = ~v4_q | ~out_stall_i;
  assign take3        = ~v3_q | take4;
  assign take2        = ~v2_q | take3;
  assign snap_stall_o = ~take2;

  assign rem = snap_i.byte_pos - snap_i.sep_pos - POS_W'(SEP_LEN);

  // checks in error order, plus per-unit products
  always_comb begin
    prod_d          = '0;
    prod_d.status   = ST_OK;
    len_ok          = 1'b0;
    prod_d.st_h     = TOTAL_W'(snap_i.start_f.hh) * TOTAL_W'(MS_PER_HOUR);
    prod_d.st_m     = MIN_PROD_W'(snap_i.start_f.mm) * MIN_PROD_W'(MS_PER_MIN);
    prod_d.st_s     = SEC_PROD_W'(snap_i.start_f.ss) * SEC_PROD_W'(MS_PER_SEC);
    prod_d.st_ms    = snap_i.start_f.ms;
    prod_d.et_h     = TOTAL_W'(snap_i.end_f.hh) * TOTAL_W'(MS_PER_HOUR);
    prod_d.et_m     = MIN_PROD_W'(snap_i.end_f.mm) * MIN_PROD_W'(MS_PER_MIN);
    prod_d.et_s     = SEC_PROD_W'(snap_i.end_f.ss) * SEC_PROD_W'(MS_PER_SEC);
    prod_d.et_ms    = snap_i.end_f.ms;
    if (!snap_i.sep_seen) begin
      prod_d.status = ST_NO_SEP;
    end else if ((snap_i.sep_pos != POS_W'(FIELD_LEN_SHORT)) &&
                 (snap_i.sep_pos != POS_W'(FIELD_LEN_LONG))) begin
      prod_d.status = ST_START_LEN;
    end else begin
      prod_d.s_short = (snap_i.sep_pos == POS_W'(FIELD_LEN_SHORT));
      // start field
      if (snap_i.flags.start_bad ||
          ((snap_i.sep_pos == POS_W'(FIELD_LEN_LONG)) && !snap_i.flags.start_d11)) begin
        prod_d.status = ST_BAD_CHAR;
      end else if (snap_i.start_f.mm > MAX_MIN_SEC) begin
        prod_d.status = ST_MINUTES;
      end else if (snap_i.start_f.ss > MAX_MIN_SEC) begin
        prod_d.status = ST_SECONDS;
      end else begin
        prod_d.start_ok = 1'b1;
        // end field length from the byte after its eleventh
        if (rem < POS_W'(FIELD_LEN_SHORT)) begin
          prod_d.status = ST_END_LEN;
        end else if (rem >= POS_W'(FIELD_LEN_LONG)) begin
          if (is_digit(snap_i.end_len_byte)) begin
            len_ok = 1'b1;
          end else if ((snap_i.end_len_byte == CH_NL) ||
                       (snap_i.end_len_byte == CH_SPACE)) begin
            len_ok         = 1'b1;
            prod_d.e_short = 1'b1;
          end else begin
            prod_d.status = ST_END_LEN;
          end
        end else begin
          len_ok         = 1'b1;
          prod_d.e_short = 1'b1;
        end
        // end field
        if (len_ok) begin
          if (snap_i.flags.end_bad) prod_d.status = ST_BAD_CHAR;
          else if (snap_i.end_f.mm > MAX_MIN_SEC) prod_d.status = ST_MINUTES;
          else if (snap_i.end_f.ss > MAX_MIN_SEC) prod_d.status = ST_SECONDS;
          else prod_d.end_ok = 1'b1;
        end
      end
    end
  end

  // totals
  always_comb begin
    sum_d.status   = prod_q.status;
    sum_d.start_ok = prod_q.start_ok;
    sum_d.end_ok   = prod_q.end_ok;
    sum_d.s_short  = prod_q.s_short;
    sum_d.e_short  = prod_q.e_short;
    sum_d.st = prod_q.st_h + TOTAL_W'(prod_q.st_m) + TOTAL_W'(prod_q.st_s) +
               TOTAL_W'(prod_q.st_ms);
    sum_d.et = prod_q.et_h + TOTAL_W'(prod_q.et_m) + TOTAL_W'(prod_q.et_s) +
               TOTAL_W'(prod_q.et_ms);
  end

  // chronology check and field masking
  always_comb begin
    res_d.s_short  = sum_q.s_short;
    res_d.e_short  = sum_q.e_short;
    res_d.start_ms = sum_q.start_ok ? sum_q.st : '0;
    res_d.end_ms   = sum_q.end_ok ? sum_q.et : '0;
    if (sum_q.end_ok && (sum_q.et <= sum_q.st)) res_d.status = ST_NOT_CHRONO;
    else res_d.status = sum_q.status;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take2) v2_q <= snap_valid_i;
      if (take3) v3_q <= v2_q;
      if (take4) v4_q <= v3_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (take2 && snap_valid_i) prod_q <= prod_d;
    if (take3 && v2_q) sum_q <= sum_d;
    if (take4 && v3_q) res_q <= res_d;
  end

  assign out_valid_o      = v4_q;
  assign start_ms_o       = res_q.start_ms;
  assign end_ms_o         = res_q.end_ms;
  assign status_o         = res_q.status;
  assign start_short_ms_o = res_q.s_short;
  assign end_short_ms_o   = res_q.e_short;

endmodule

FILE: hdl/srt_timestamp_line_parser.sv
// Timing line parser: one byte per cycle in unless stalled, one result per
// marked last byte. Throughput: one byte beat per cycle while not stalled,
// sustained, lines back to back. A result passes, in order, through the
// line snapshot, products, totals and output registers.
// Reset: asynchronous active-low; clears the line state and all valid flags.
// Depends on stl_pkg, stl_byte_scan and stl_time_calc.

module srt_timestamp_line_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   line_byte_i,
  input  logic                         line_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [stl_pkg::TOTAL_W-1:0]  start_ms_o,
  output logic [stl_pkg::TOTAL_W-1:0]  end_ms_o,
  output logic [2:0]                   status_o,
  output logic                         start_short_ms_o,
  output logic                         end_short_ms_o
);
  import stl_pkg::*;

  logic  snap_valid;
  logic  snap_stall;
  snap_t snap;

  // byte scanner
  stl_byte_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .line_byte_i  (line_byte_i),
    .line_last_i  (line_last_i),
    .snap_valid_o (snap_valid),
    .snap_stall_i (snap_stall),
    .snap_o       (snap)
  );

  // result pipeline
  stl_time_calc u_calc (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_stall_o     (snap_stall),
    .snap_i           (snap),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .start_ms_o       (start_ms_o),
    .end_ms_o         (end_ms_o),
    .status_o         (status_o),
    .start_short_ms_o (start_short_ms_o),
    .end_short_ms_o   (end_short_ms_o)
  );

endmodule

FILE: hdl/stl_checker.sv
// Port-level checks for the timing line parser, bound to the top level.
// Depends on stl_pkg and srt_timestamp_line_parser.

module stl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [7:0]                   line_byte_i,
  input logic                         line_last_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [stl_pkg::TOTAL_W-1:0]  start_ms_o,
  input logic [stl_pkg::TOTAL_W-1:0]  end_ms_o,
  input logic [2:0]                   status_o,
  input logic                         start_short_ms_o,
  input logic                         end_short_ms_o
);
  import stl_pkg::*;

  // a stalled byte beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(line_byte_i) &&
    $stable(line_last_i))
    else $error("byte beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(start_ms_o) &&
    $stable(end_ms_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // an ok line ends after it starts
  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> end_ms_o > start_ms_o)
    else $error("ok status with end not after start");

  // separator or start length errors carry no times and no warning
  a_early_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_NO_SEP) || (status_o == ST_START_LEN)) |->
    (start_ms_o == '0) && (end_ms_o == '0) && !start_short_ms_o && !end_short_ms_o)
    else $error("early error with nonzero fields");

  // an end time is only reported for a fully parsed line
  a_end_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (end_ms_o != '0) |->
    (status_o == ST_OK) || (status_o == ST_NOT_CHRONO))
    else $error("end time reported with an error status");

endmodule

bind srt_timestamp_line_parser stl_checker u_stl_checker (.*);

FILE: tb/sv/tb_srt_timestamp_line_parser.sv
// Self-checking bench for the timing line parser: feeds whole timing lines a byte
// per beat and checks each line result against a built-in line scanner.
// Depends on stl_pkg (status codes, total width) and srt_timestamp_line_parser.

module tb_srt_timestamp_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  // scanner constants
  localparam int unsigned LINE_BYTES_MAX = 1024;
  localparam bit [31:0]   ARROW_HEAD     = 32'h202D2D3E;
  localparam bit [7:0]    C_NUL          = 8'h00;
  localparam bit [7:0]    C_NL           = 8'h0A;
  localparam bit [7:0]    C_SP           = 8'h20;
  localparam bit [7:0]    C_COMMA        = 8'h2C;
  localparam bit [7:0]    C_COLON        = 8'h3A;
  localparam bit [7:0]    C_ZERO         = 8'h30;
  localparam bit [7:0]    C_NINE         = 8'h39;

  typedef struct packed {
    bit [7:0] b;
    bit       last;
  } line_beat_t;

  typedef struct packed {
    bit [6:0] hh;
    bit [6:0] mm;
    bit [6:0] ss;
    bit [9:0] ms;
  } clock_fields_t;

  typedef struct {
    bit [TOTAL_W-1:0] start_ms;
    bit [TOTAL_W-1:0] end_ms;
    status_e          status;
    bit               start_short;
    bit               end_short;
  } timing_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           line_byte_i      = 8'h00;
  logic                 line_last_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [TOTAL_W-1:0]   start_ms_o;
  logic [TOTAL_W-1:0]   end_ms_o;
  logic [2:0]           status_o;
  logic                 start_short_ms_o;
  logic                 end_short_ms_o;

  line_beat_t  line_beats[$];
  timing_t     due_timings[$];
  bit [7:0]    line_buf[$];
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatch_count = 0;
  int unsigned queued_beats   = 0;

  // per-line scanner state
  bit [10:0]     scan_pos;
  bit [31:0]     scan_recent;
  bit [10:0]     scan_sep_pos;
  bit            scan_sep_seen;
  clock_fields_t scan_start;
  clock_fields_t scan_end;
  bit            scan_start_bad;
  bit            scan_start_d11;
  bit            scan_end_bad;
  bit            scan_end_d11;
  bit [7:0]      scan_end_len_byte;
  bit            scan_ended;

  srt_timestamp_line_parser DUT (.*);

  always #5 clk_i = ~clk_i;

  initial begin : reset_gen
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_srt_timestamp_line_parser: done, errors");
    $finish;
  end

  function automatic void clear_scan();
    scan_pos          = '0;
    scan_recent       = '0;
    scan_sep_pos      = '0;
    scan_sep_seen     = 1'b0;
    scan_start        = '0;
    scan_end          = '0;
    scan_start_bad    = 1'b0;
    scan_start_d11    = 1'b0;
    scan_end_bad      = 1'b0;
    scan_end_d11      = 1'b0;
    scan_end_len_byte = '0;
    scan_ended        = 1'b0;
  endfunction

  // check one byte of a timestamp field and shift its digit in
  function automatic void fold_stamp_byte(inout clock_fields_t f, input int unsigned idx,
                                          input bit [7:0] b, inout bit bad, inout bit d11);
    bit       dig;
    bit [3:0] d;
    dig = (b >= C_ZERO) && (b <= C_NINE);
    d   = dig ? 4'(b - C_ZERO) : 4'd0;
    case (idx)
      2, 5: if (b != C_COLON) bad = 1'b1;
      8:    if (b != C_COMMA) bad = 1'b1;
      0, 1: if (!dig) bad = 1'b1; else f.hh = 7'(f.hh * 10 + d);
      3, 4: if (!dig) bad = 1'b1; else f.mm = 7'(f.mm * 10 + d);
      6, 7: if (!dig) bad = 1'b1; else f.ss = 7'(f.ss * 10 + d);
      9, 10: if (!dig) bad = 1'b1; else f.ms = 10'(f.ms * 10 + d);
      11: begin
        if (dig) begin
          d11  = 1'b1;
          f.ms = 10'(f.ms * 10 + d);
        end
      end
      default: ;
    endcase
  endfunction

  // range check, total in milliseconds on success
  function automatic status_e stamp_total(input clock_fields_t f, output int unsigned total);
    total = 0;
    if (f.mm > 59) return ST_MINUTES;
    if (f.ss > 59) return ST_SECONDS;
    total = f.hh * 3600000 + f.mm * 60000 + f.ss * 1000 + f.ms;
    return ST_OK;
  endfunction

  // one text byte into the scanner
  function automatic void scan_text_byte(input bit [7:0] b);
    int unsigned rel;
    if (b == C_NUL) begin
      scan_ended = 1'b1;
      return;
    end
    if (scan_pos >= LINE_BYTES_MAX - 1) return;
    if (scan_pos < 12)
      fold_stamp_byte(scan_start, scan_pos, b, scan_start_bad, scan_start_d11);
    if (scan_sep_seen) begin
      rel = scan_pos - scan_sep_pos - 5;
      if (rel < 12) fold_stamp_byte(scan_end, rel, b, scan_end_bad, scan_end_d11);
      if (rel == 11) scan_end_len_byte = b;
    end else if (scan_pos >= 4 && scan_recent == ARROW_HEAD && b == C_SP) begin
      scan_sep_seen = 1'b1;
      scan_sep_pos  = 11'(scan_pos - 4);
    end
    scan_recent = {scan_recent[23:0], b};
    scan_pos    = 11'(scan_pos + 1);
  endfunction

  // line result from the scanner state, first error wins
  function automatic timing_t close_line();
    timing_t     r;
    int unsigned st_ms;
    int unsigned en_ms;
    int unsigned rem;
    bit [7:0]    lb;
    r.start_ms    = '0;
    r.end_ms      = '0;
    r.status      = ST_OK;
    r.start_short = 1'b0;
    r.end_short   = 1'b0;
    st_ms = 0;
    en_ms = 0;
    if (!scan_sep_seen) begin
      r.status = ST_NO_SEP;
    end else if (scan_sep_pos != 11 && scan_sep_pos != 12) begin
      r.status = ST_START_LEN;
    end else begin
      r.start_short = (scan_sep_pos == 11);
      if (scan_start_bad || (scan_sep_pos == 12 && !scan_start_d11))
        r.status = ST_BAD_CHAR;
      else
        r.status = stamp_total(scan_start, st_ms);
      if (r.status == ST_OK) begin
        r.start_ms = TOTAL_W'(st_ms);
        rem = scan_pos - scan_sep_pos - 5;
        // end field length from the byte after its eleventh
        if (rem < 11) begin
          r.status = ST_END_LEN;
        end else if (rem >= 12) begin
          lb = scan_end_len_byte;
          if (lb >= C_ZERO && lb <= C_NINE) r.end_short = 1'b0;
          else if (lb == C_NL || lb == C_SP) r.end_short = 1'b1;
          else r.status = ST_END_LEN;
        end else begin
          r.end_short = 1'b1;
        end
        if (r.status == ST_OK) begin
          if (scan_end_bad) r.status = ST_BAD_CHAR;
          else r.status = stamp_total(scan_end, en_ms);
          if (r.status == ST_OK) begin
            r.end_ms = TOTAL_W'(en_ms);
            if (en_ms <= st_ms) r.status = ST_NOT_CHRONO;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void predict_beat(input bit [7:0] b, input bit last);
    if (!scan_ended) scan_text_byte(b);
    if (last) begin
      due_timings.push_back(close_line());
      clear_scan();
    end
  endfunction

  // byte driver, predicts on every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    line_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      line_byte_i <= 8'h00;
      line_last_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_beat(line_byte_i, line_last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (line_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = line_beats.pop_front();
          in_valid_i  <= 1'b1;
          line_byte_i <= nxt.b;
          line_last_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    timing_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_timings.size() == 0) begin
          $error("result with no line pending: start_ms %0d end_ms %0d status %0d",
                 start_ms_o, end_ms_o, status_o);
          mismatch_count++;
        end else begin
          want = due_timings.pop_front();
          if (start_ms_o !== want.start_ms) begin
            $error("start_ms: expected %0d, got %0d", want.start_ms, start_ms_o);
            mismatch_count++;
          end
          if (end_ms_o !== want.end_ms) begin
            $error("end_ms: expected %0d, got %0d", want.end_ms, end_ms_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (start_short_ms_o !== want.start_short) begin
            $error("start_short_ms: expected %0d, got %0d", want.start_short,
                   start_short_ms_o);
            mismatch_count++;
          end
          if (end_short_ms_o !== want.end_short) begin
            $error("end_short_ms: expected %0d, got %0d", want.end_short, end_short_ms_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // line text builders
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_num(input int unsigned v, input int unsigned digits);
    int unsigned p;
    for (int k = digits - 1; k >= 0; k--) begin
      p = 10 ** k;
      line_buf.push_back(8'(C_ZERO + (v / p) % 10));
    end
  endfunction

  function automatic void add_stamp(input int unsigned h, input int unsigned m,
                                    input int unsigned s, input int unsigned ms,
                                    input bit two_ms);
    add_num(h, 2);
    line_buf.push_back(C_COLON);
    add_num(m, 2);
    line_buf.push_back(C_COLON);
    add_num(s, 2);
    line_buf.push_back(C_COMMA);
    add_num(ms, two_ms ? 2 : 3);
  endfunction

  function automatic void add_arrow();
    for (int i = 3; i >= 0; i--) line_buf.push_back(ARROW_HEAD[8*i +: 8]);
    line_buf.push_back(C_SP);
  endfunction

  // move the built line into the beat queue, last byte marked
  function automatic void flush_line();
    if (line_buf.size() == 0) line_buf.push_back(C_NL);
    foreach (line_buf[i])
      line_beats.push_back('{b: line_buf[i], last: (i == line_buf.size() - 1)});
    queued_beats += line_buf.size();
    line_buf.delete();
  endfunction

  function automatic int unsigned pick_min_sec();
    return ($urandom_range(7) == 0) ? $urandom_range(99, 60) : $urandom_range(59);
  endfunction

  // well-formed timing text with random content and trailer
  function automatic void add_timing_text();
    int unsigned sh, sm, ss, sms, eh, em, es, ems;
    bit          s2, e2;
    sh  = $urandom_range(99);
    sm  = pick_min_sec();
    ss  = pick_min_sec();
    s2  = ($urandom_range(3) == 0);
    sms = s2 ? $urandom_range(99) : $urandom_range(999);
    e2  = ($urandom_range(3) == 0);
    ems = e2 ? $urandom_range(99) : $urandom_range(999);
    case ($urandom_range(3))
      0: begin
        eh = $urandom_range(99);
        em = pick_min_sec();
        es = pick_min_sec();
      end
      1: begin
        // same second, order decided by the millisecond digits
        eh = sh;
        em = sm;
        es = ss;
      end
      default: begin
        eh = $urandom_range(99, sh);
        em = pick_min_sec();
        es = pick_min_sec();
      end
    endcase
    add_stamp(sh, sm, ss, sms, s2);
    add_arrow();
    add_stamp(eh, em, es, ems, e2);
    case ($urandom_range(5))
      0: ;
      1: line_buf.push_back(C_NL);
      2: line_buf.push_back(C_SP);
      3: repeat ($urandom_range(3, 1)) line_buf.push_back(8'($urandom_range(255)));
      4: add_text("\r\n");
      default: begin
        line_buf.push_back(C_SP);
        add_text("X1 Y2\n");
      end
    endcase
  endfunction

  function automatic void add_random_line();
    int unsigned pick, at;
    pick = $urandom_range(99);
    if (pick < 80) begin
      add_timing_text();
      // occasional broken line: overwrite, drop or insert one byte
      if ($urandom_range(3) == 0) begin
        at = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(2))
          0: line_buf[at] = 8'($urandom_range(255));
          1: line_buf.delete(at);
          default: line_buf.insert(at, 8'($urandom_range(255)));
        endcase
      end
    end else if (pick < 93) begin
      repeat ($urandom_range(40, 1)) line_buf.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) begin
        at = $urandom_range(line_buf.size());
        for (int i = 3; i >= 0; i--) line_buf.insert(at++, ARROW_HEAD[8*i +: 8]);
        line_buf.insert(at, C_SP);
      end
    end else begin
      add_timing_text();
      line_buf.insert($urandom_range(line_buf.size()), C_NUL);
    end
    flush_line();
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (line_beats.size() != 0 || in_valid_i || due_timings.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned first_beat;
    int unsigned lines;
    clear_scan();

    // directed lines
    add_text("01:02:03,456 --> 01:02:04,567");   flush_line();
    add_text("00:00:00,000 --> 99:59:59,999\n"); flush_line();
    add_text("99:59:59,999 --> 00:00:00,001");   flush_line();
    add_text("00:00:01,50 --> 00:00:02,75");     flush_line();
    add_text("00:00:01,50 --> 00:00:02,75\n");   flush_line();
    add_text("00:00:01,500 --> 00:00:02,75 x");  flush_line();
    add_text("00:00:01,500 --> 00:00:02,75x");   flush_line();
    add_text("00:00:01,500 --> 00:00:02,7");     flush_line();
    add_text("no separator here");               flush_line();
    add_text("00:00:01,000 -->00:00:02,000");    flush_line();
    add_text(" --> 00:00:01,000");               flush_line();
    add_text("0:00:01,500 --> 00:00:02,750");    flush_line();
    add_text("00:00:01,5000 --> 00:00:02,750");  flush_line();
    add_text("00:00:01,50x --> 00:00:02,750");   flush_line();
    add_text("00:60:00,000 --> 01:00:00,000");   flush_line();
    add_text("00:00:60,000 --> 01:00:00,000");   flush_line();
    add_text("00:00:01;000 --> 00:00:02,000");   flush_line();
    add_text("00:00:01,000 --> 00:61:00,000");   flush_line();
    add_text("00:00:01,000 --> 00:00:61,000");   flush_line();
    add_text("00:00:01,000 --> 00:0a:00,000");   flush_line();
    add_text("00:00:05,000 --> 00:00:05,000");   flush_line();
    add_text("00:00:05,000 --> 00:00:04,999");   flush_line();
    add_text("00:00:01,000 --> --> 00:00:02,000"); flush_line();
    flush_line();
    // text cut short by a null byte
    add_text("00:00:01,000 --> 00:0");
    line_buf.push_back(C_NUL);
    add_text("0:02,000");
    flush_line();
    line_buf.push_back(C_NUL);
    add_text("00:00:01,000 --> 00:00:02,000");
    flush_line();
    // overlong line: a separator and trailing bytes past the limit
    repeat (1020) line_buf.push_back("x");
    add_text(" --> 00:00:01,000");
    flush_line();
    wait_drained();

    // random lines under each idling mode, draining between modes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      first_beat = queued_beats;
      lines = 0;
      while (queued_beats - first_beat < 100 || lines < 3) begin
        add_random_line();
        lines++;
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("tb_srt_timestamp_line_parser: done, clean");
    else
      $display("tb_srt_timestamp_line_parser: done, errors");
    $finish;
  end

endmodule
